// File: rtl/core/art_pkg.sv
package art_pkg;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_ACK   = 3'd1,
      OP_PICK  = 3'd2,
      OP_SENT  = 3'd3,
      OP_TICK  = 3'd4,
      OP_PURGE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_NOT_SENT  = 3'd4,
      ST_NONE      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ACT,
      S_SHIFT,
      S_TICK,
      S_DONE
   } state_type;

   localparam int CSR_TIMEOUT     = 0;
   localparam int CSR_RETRY_LIMIT = 1;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   localparam int OP_BITS         = 3;
   localparam int SERIAL_BITS     = 32;
   localparam int STATUS_BITS     = 3;
   localparam int OUT_HANDLE_BITS = 8;
   localparam int TIMER_BITS      = 16;
   localparam int RETRY_BITS      = 4;

endpackage

// File: rtl/core/art_if.sv
interface art_req_if;
   logic                   valid;
   logic                   ready;
   logic [2:0]             operation;
   logic [31:0]            serial_number;
   logic                   needs_ack;
   logic [7:0]             packet_handle;

   modport source (output valid, operation, serial_number, needs_ack, packet_handle,
                   input ready);
   modport sink   (input valid, operation, serial_number, needs_ack, packet_handle,
                   output ready);
endinterface

interface art_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [2:0]             status;
   logic [31:0]            found_serial;
   logic [7:0]             found_handle;
   logic                   found_needs_ack;
   logic                   entry_removed;

   modport source (output valid, status, found_serial, found_handle, found_needs_ack,
                   entry_removed, input ready);
   modport sink   (input valid, status, found_serial, found_handle, found_needs_ack,
                   entry_removed, output ready);
endinterface

// File: rtl/core/art_ram.sv
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/ack_retransmit_table.sv
// ack_retransmit_table: ordered table of pending transmissions.
// req channel carries one operation item (add, ack, pick, mark sent, tick,
// purge); rsp channel returns exactly one result item per request.
// csr_ write port sets timeout_ticks (index 0) and retry_limit (index 1).
// Entries live in one single-port-write, registered-read RAM, oldest at
// address 0. A search reads one entry per cycle and stops at the first hit;
// a removal then shifts the younger entries down one per cycle, and a tick
// rewrites each valid entry in turn. A result is held in the rsp register
// until taken; req is accepted only when the table is idle and the rsp
// register is empty, so the next item is taken in the cycle after the
// result leaves; no new item is taken while the receiver stalls.
// Reset (synchronous) empties the table and restores register defaults;
// no clearing pass is needed since occupancy bounds every read.
module ack_retransmit_table
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int HANDLE_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   art_req_if.sink                   req,
   art_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = SERIAL_BITS + HANDLE_BITS + 1 + 1 + TIMER_BITS + RETRY_BITS;

   typedef struct packed {
      logic [SERIAL_BITS-1:0] serial;
      logic [HANDLE_BITS-1:0] handle;
      logic                   ack_req;
      logic                   sent;
      logic [TIMER_BITS-1:0]  timer;
      logic [RETRY_BITS-1:0]  retries;
   } entry_type;

   state_type              state_ff, state_in;
   logic [TIMER_BITS-1:0]  timeout_ff;
   logic [RETRY_BITS-1:0]  limit_ff;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          idx_ff, idx_in;      // entry whose read is in flight
   logic                   rd_live_ff, rd_live_in;
   op_type                 op_ff;
   logic [SERIAL_BITS-1:0] sn_ff;
   logic                   nack_ff;
   logic [HANDLE_BITS-1:0] hdl_ff;
   logic [AW-1:0]          hit_ff, hit_in;
   logic                   found_ff, found_in;
   entry_type              hit_e_ff, hit_e_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] st_ff, st_in;
   logic [SERIAL_BITS-1:0] fs_ff, fs_in;
   logic [7:0]             fh_ff, fh_in;
   logic                   fa_ff, fa_in;
   logic                   rm_ff, rm_in;
   logic                   res_load;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   entry_type              wr_e, rd_e;
   logic [EW-1:0]          rd_raw;
   logic                   req_fire, rsp_free;

   assign rd_e = entry_type'(rd_raw);

   art_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(EW'(wr_e)),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire = req.valid && req.ready;

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      rd_live_in = 1'b0;
      hit_in     = hit_ff;
      found_in   = found_ff;
      hit_e_in   = hit_e_ff;
      rd_addr    = idx_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_e       = rd_e;
      res_load   = 1'b0;
      st_in      = STATUS_BITS'(ST_OK);
      fs_in      = '0;
      fh_in      = '0;
      fa_in      = 1'b0;
      rm_in      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in     = '0;
               rd_addr    = '0;
               found_in   = 1'b0;
               rd_live_in = occ_ff != '0;
               unique case (req.operation)
                  OP_ADD, OP_ACK, OP_SENT, OP_PICK, OP_PURGE: state_in = S_SCAN;
                  OP_TICK: state_in = S_TICK;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // rd_e holds entry idx_ff when rd_live_ff
            if (rd_live_ff && !found_in) begin
               priority case (op_ff)
                  OP_PICK:  found_in = !rd_e.sent;
                  OP_PURGE: found_in = rd_e.retries >= limit_ff;
                  default:  found_in = rd_e.serial == sn_ff;
               endcase
               if (found_in) begin
                  hit_in   = idx_ff[AW-1:0];
                  hit_e_in = rd_e;
               end
            end
            if (rd_live_ff && !found_in && (idx_ff + 1'b1) < occ_ff) begin
               idx_in     = idx_ff + 1'b1;
               rd_addr    = idx_in[AW-1:0];
               rd_live_in = 1'b1;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            res_load = 1'b1;
            state_in = S_DONE;
            if (op_ff == OP_ADD) begin
               if (occ_ff >= CW'(TABLE_DEPTH)) begin
                  st_in = STATUS_BITS'(ST_FULL);
               end else if (found_ff) begin
                  st_in = STATUS_BITS'(ST_DUPLICATE);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = occ_ff[AW-1:0];
                  wr_e    = '{serial: sn_ff, handle: hdl_ff, ack_req: nack_ff,
                              sent: 1'b0, timer: '0, retries: '0};
                  occ_in  = occ_ff + 1'b1;
               end
            end else if (!found_ff) begin
               st_in = STATUS_BITS'((op_ff == OP_PICK || op_ff == OP_PURGE) ?
                                    ST_NONE : ST_NOT_FOUND);
            end else begin
               fs_in = hit_e_ff.serial;
               fh_in = 8'(hit_e_ff.handle);
               fa_in = hit_e_ff.ack_req;
               if ((op_ff == OP_ACK && hit_e_ff.sent) || op_ff == OP_PURGE ||
                   (op_ff == OP_SENT && !hit_e_ff.ack_req)) begin
                  rm_in      = 1'b1;
                  idx_in     = CW'(hit_ff) + 1'b1;
                  rd_addr    = idx_in[AW-1:0];
                  rd_live_in = idx_in < occ_ff;
                  state_in   = S_SHIFT;
               end else if (op_ff == OP_ACK) begin
                  st_in = STATUS_BITS'(ST_NOT_SENT);
               end else if (op_ff == OP_SENT) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_ff;
                  wr_e    = hit_e_ff;
                  wr_e.sent = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            // rd_e holds entry idx_ff; move it to idx_ff-1
            if (rd_live_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff - 1'b1);
               wr_e    = rd_e;
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_in[AW-1:0];
               rd_live_in = idx_in < occ_ff;
            end else begin
               occ_in   = occ_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_TICK: begin
            if (rd_live_ff) begin
               wr_en = 1'b1;
               wr_e  = rd_e;
               if (rd_e.sent && rd_e.retries < limit_ff) begin
                  if (rd_e.timer < timeout_ff) begin
                     wr_e.timer = rd_e.timer + 1'b1;
                  end else begin
                     wr_e.timer   = '0;
                     wr_e.retries = rd_e.retries + 1'b1;
                     wr_e.sent    = 1'b0;
                  end
               end
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_in[AW-1:0];
               rd_live_in = idx_in < occ_ff;
            end else begin
               res_load = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (state_ff == S_DONE) ? 1'b1 :
                         (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMER_BITS'(100);
         limit_ff     <= RETRY_BITS'(3);
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_live_ff   <= rd_live_in;
         if (state_ff == S_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= rsp_valid_in;
         end
         if (csr_write_enable && csr_index == CSR_INDEX_BITS'(CSR_TIMEOUT)) begin
            timeout_ff <= csr_write_data[TIMER_BITS-1:0];
         end
         if (csr_write_enable && csr_index == CSR_INDEX_BITS'(CSR_RETRY_LIMIT)) begin
            limit_ff <= csr_write_data[RETRY_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      hit_e_ff <= hit_e_in;
      if (req_fire) begin
         op_ff   <= op_type'(req.operation);
         sn_ff   <= req.serial_number;
         nack_ff <= req.needs_ack;
         hdl_ff  <= HANDLE_BITS'(req.packet_handle);
      end
      if (res_load) begin
         st_ff <= st_in;
         fs_ff <= fs_in;
         fh_ff <= fh_in;
         fa_ff <= fa_in;
         rm_ff <= rm_in;
      end else if (req_fire) begin
         st_ff <= STATUS_BITS'(ST_OK);
         fs_ff <= '0;
         fh_ff <= '0;
         fa_ff <= 1'b0;
         rm_ff <= 1'b0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = st_ff;
   assign rsp.found_serial    = fs_ff;
   assign rsp.found_handle    = fh_ff;
   assign rsp.found_needs_ack = fa_ff;
   assign rsp.entry_removed   = rm_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(TABLE_DEPTH))
      else $error("occupancy above depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request not taken up");
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rm_ff |-> st_ff == STATUS_BITS'(ST_OK))
      else $error("removal with error status");
   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      occ_ff != $past(occ_ff) |-> state_ff == S_DONE)
      else $error("occupancy changed outside completion");
endmodule
